/* design/ipaf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IP address filter table package
// Shared sizes, command and status codes, and the control and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ipaf_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W      = 32;
    localparam int OUT_CNT_W   = 6;

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic load;
        logic scan;
        logic apply;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_busy;
    } dp_status_t;

endpackage
`default_nettype wire

/* design/ipaf_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IP address filter table controller
// Sequences each request through accept, table scan, final compare and the
// table update that also loads the result register.
// ----------------------------------------------------------------------------
module ipaf_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire ipaf_pkg::dp_status_t dp_status,
    output ipaf_pkg::ctrl_cmd_t     dp_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_APPLY = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next   = state_reg;
        dp_cmd.load  = 1'b0;
        dp_cmd.scan  = 1'b0;
        dp_cmd.apply = 1'b0;
        req_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                req_ready = aresetn;
                if (req_valid && aresetn) begin
                    dp_cmd.load = 1'b1;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN: begin
                dp_cmd.scan = 1'b1;
                if (dp_status.scan_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next = S_APPLY;
            end
            S_APPLY: begin
                if (!dp_status.out_busy) begin
                    dp_cmd.apply = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

/* design/ipaf_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IP address filter table datapath
// Holds the address memory, the entry valid marks and the count, scans the
// table one slot per cycle, and registers the result.
// ----------------------------------------------------------------------------
module ipaf_dp (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [1:0]                    in_cmd,
    input  wire logic [ipaf_pkg::ADDR_W-1:0]   in_addr,
    input  wire ipaf_pkg::ctrl_cmd_t           dp_cmd,
    output ipaf_pkg::dp_status_t               dp_status,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               out_hit,
    output logic [1:0]                         out_status,
    output logic [ipaf_pkg::OUT_CNT_W-1:0]     out_count
);

    logic [ipaf_pkg::ADDR_W-1:0] mem [ipaf_pkg::TABLE_DEPTH];
    logic [ipaf_pkg::TABLE_DEPTH-1:0] valid_reg;
    logic [ipaf_pkg::CNT_W-1:0] count_reg;

    logic [1:0]                  cmd_reg;
    logic [ipaf_pkg::ADDR_W-1:0] addr_reg;
    logic [ipaf_pkg::IDX_W-1:0]  scan_idx_reg;

    logic [ipaf_pkg::ADDR_W-1:0] rd_data_reg;
    logic                        rd_valid_reg;
    logic [ipaf_pkg::IDX_W-1:0]  rd_idx_reg;
    logic                        cmp_en_reg;

    logic                        match_found_reg;
    logic [ipaf_pkg::IDX_W-1:0]  match_slot_reg;
    logic                        free_found_reg;
    logic [ipaf_pkg::IDX_W-1:0]  free_slot_reg;

    logic                        out_valid_reg;
    logic                        out_hit_reg;
    logic [1:0]                  out_status_reg;
    logic [ipaf_pkg::OUT_CNT_W-1:0] out_count_reg;

    logic [ipaf_pkg::CNT_W-1:0]  count_next;
    logic [1:0]                  status_next;
    logic                        do_insert;
    logic                        do_delete;

    assign dp_status.scan_last = (scan_idx_reg == ipaf_pkg::IDX_W'(ipaf_pkg::TABLE_DEPTH - 1));
    assign dp_status.out_busy  = out_valid_reg && !out_ready;

    assign out_valid  = out_valid_reg;
    assign out_hit    = out_hit_reg;
    assign out_status = out_status_reg;
    assign out_count  = out_count_reg;

    always_comb begin
        do_insert   = 1'b0;
        do_delete   = 1'b0;
        status_next = ipaf_pkg::ST_OK;
        count_next  = count_reg;
        case (cmd_reg)
            ipaf_pkg::CMD_INSERT: begin
                if (free_found_reg) begin
                    do_insert  = 1'b1;
                    count_next = ipaf_pkg::CNT_W'(count_reg + 1'b1);
                end else begin
                    status_next = ipaf_pkg::ST_FULL;
                end
            end
            ipaf_pkg::CMD_DELETE: begin
                if (match_found_reg) begin
                    do_delete  = 1'b1;
                    count_next = ipaf_pkg::CNT_W'(count_reg - 1'b1);
                end else begin
                    status_next = ipaf_pkg::ST_NOT_FOUND;
                end
            end
            default: begin
                status_next = ipaf_pkg::ST_OK;
            end
        endcase
    end

    // Address memory: one registered read per scan cycle, one write on update.
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[scan_idx_reg];
        if (dp_cmd.apply && do_insert) begin
            mem[free_slot_reg] <= addr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.load) begin
            cmd_reg  <= in_cmd;
            addr_reg <= in_addr;
        end
        rd_valid_reg <= valid_reg[scan_idx_reg];
        rd_idx_reg   <= scan_idx_reg;
        if (dp_cmd.apply) begin
            out_hit_reg    <= match_found_reg;
            out_status_reg <= status_next;
            out_count_reg  <= ipaf_pkg::OUT_CNT_W'(count_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg       <= '0;
            count_reg       <= '0;
            scan_idx_reg    <= '0;
            cmp_en_reg      <= 1'b0;
            match_found_reg <= 1'b0;
            match_slot_reg  <= '0;
            free_found_reg  <= 1'b0;
            free_slot_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            cmp_en_reg <= dp_cmd.scan;
            if (dp_cmd.load) begin
                scan_idx_reg    <= '0;
                match_found_reg <= 1'b0;
                free_found_reg  <= 1'b0;
            end else if (dp_cmd.scan && !dp_status.scan_last) begin
                scan_idx_reg <= ipaf_pkg::IDX_W'(scan_idx_reg + 1'b1);
            end
            if (cmp_en_reg) begin
                if (rd_valid_reg && (rd_data_reg == addr_reg) && !match_found_reg) begin
                    match_found_reg <= 1'b1;
                    match_slot_reg  <= rd_idx_reg;
                end
                if (!rd_valid_reg && !free_found_reg) begin
                    free_found_reg <= 1'b1;
                    free_slot_reg  <= rd_idx_reg;
                end
            end
            if (dp_cmd.apply) begin
                count_reg <= count_next;
                if (do_insert) begin
                    valid_reg[free_slot_reg] <= 1'b1;
                end
                if (do_delete) begin
                    valid_reg[match_slot_reg] <= 1'b0;
                end
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

/* design/ip_address_filter_table.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IP address filter table
// A bounded table of IPv4 addresses supporting lookup, insert and delete.
//
//   Channel   Direction  Contents
//   s_axis    in         tdata: cmd[1:0], ip_addr[33:2], zero pad[39:34]
//   m_axis    out        tdata: hit[0], status[2:1], entry_count[8:3], pad
//
// Each request passes through an accept step, one read per table slot through
// the single memory read port, the last compare and the update. A new request
// is accepted while the previous result waits; the update stalls until the
// result register is free.
// Reset clears the valid marks, the entry count and all control state.
// ----------------------------------------------------------------------------
module ip_address_filter_table (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // cmd, ip_addr, zero pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // hit, status, entry_count, zero pad
);

    ipaf_pkg::ctrl_cmd_t  dp_cmd;
    ipaf_pkg::dp_status_t dp_status;

    logic                              out_hit;
    logic [1:0]                        out_status;
    logic [ipaf_pkg::OUT_CNT_W-1:0]    out_count;

    ipaf_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    ipaf_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_cmd     (s_tdata[1:0]),
        .in_addr    (s_tdata[33:2]),
        .dp_cmd     (dp_cmd),
        .dp_status  (dp_status),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_hit    (out_hit),
        .out_status (out_status),
        .out_count  (out_count)
    );

    assign m_tdata = {7'd0, out_count, out_status, out_hit};

endmodule
`default_nettype wire
